// ===== src/ocf_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths and defaults for the open-channel flow pipeline.
// No dependencies; every module of the block imports this package.
package ocf_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int DEPTH_W    = 24;
   localparam int WIDTH_W    = 24;
   localparam int FACTOR_W   = 24;
   localparam int TARGET_W   = 32;
   localparam int MAXD_W     = 24;
   localparam int TOL_W      = 23;
   localparam int FLOW_W     = 32;
   localparam int ERR_W      = 32;
   localparam int ROOT_W     = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

endpackage

// ===== src/ocf_radius.sv =====
`timescale 1ns / 1ps
// Depth front end: range check, W*d*factor product and the pipelined
// restoring divider for the hydraulic radius. Depends on ocf_pkg.
module ocf_radius #(
   parameter int FRAC_BITS = ocf_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [ocf_pkg::DEPTH_W-1:0]         in_depth,
   input  logic [ocf_pkg::WIDTH_W-1:0]         cfg_width,
   input  logic [ocf_pkg::FACTOR_W-1:0]        cfg_factor,
   input  logic [ocf_pkg::MAXD_W-1:0]          cfg_max_depth,
   output logic                                out_valid,
   output logic [ocf_pkg::ROOT_W-1:0]          out_radius,
   output logic [ocf_pkg::FACTOR_W+ocf_pkg::DEPTH_W+ocf_pkg::WIDTH_W-2*FRAC_BITS-1:0] out_prod,
   output logic                                out_in_range
);
   import ocf_pkg::*;

   localparam int NUM_W = WIDTH_W + DEPTH_W;
   localparam int DEN_W = DEPTH_W + 2;
   localparam int FA_W  = FACTOR_W + DEPTH_W;
   localparam int A_W   = FA_W - FRAC_BITS;
   localparam int AB_W  = A_W + WIDTH_W;
   localparam int B_W   = AB_W - FRAC_BITS;
   localparam int STEPS = ROOT_W;
   localparam int CMP_W = NUM_W + 2;

   typedef struct packed {
      logic             in_range;
      logic             zero;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [A_W-1:0]   a;
   } front_type;

   typedef struct packed {
      logic              in_range;
      logic              zero;
      logic [NUM_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [ROOT_W-1:0] quo;
      logic [B_W-1:0]    prod;
   } div_type;

   logic [STEPS:0]  vld_ff;
   front_type       front_ff, front_in;
   div_type         div_ff [STEPS];
   div_type         div_in [STEPS];
   logic [FA_W-1:0] fa_prod;
   logic [AB_W-1:0] ab_prod;

   always_comb begin
      fa_prod           = FA_W'(cfg_factor) * FA_W'(in_depth);
      front_in.in_range = in_depth <= cfg_max_depth;
      front_in.zero     = (in_depth == '0) && (cfg_width == '0);
      front_in.num      = NUM_W'(cfg_width) * NUM_W'(in_depth);
      front_in.den      = DEN_W'({in_depth, 1'b0}) + DEN_W'(cfg_width);
      front_in.a        = A_W'(fa_prod >> FRAC_BITS);
   end

   always_comb begin
      div_type          src;
      logic [CMP_W-1:0] shifted;
      ab_prod = AB_W'(front_ff.a) * AB_W'(cfg_width);
      for (int i = 0; i < STEPS; i++) begin
         if (i == 0) begin
            src.in_range = front_ff.in_range;
            src.zero     = front_ff.zero;
            src.rem      = front_ff.num;
            src.den      = front_ff.den;
            src.quo      = '0;
            src.prod     = B_W'(ab_prod >> FRAC_BITS);
         end else begin
            src = div_ff[i-1];
         end
         div_in[i] = src;
         shifted   = CMP_W'(src.den) << (STEPS - 1 - i);
         if (CMP_W'(src.rem) >= shifted) begin
            div_in[i].rem                 = src.rem - NUM_W'(shifted);
            div_in[i].quo[STEPS - 1 - i]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STEPS-1:0], in_valid};
      end
      if (advance) begin
         front_ff <= front_in;
         for (int i = 0; i < STEPS; i++) begin
            div_ff[i] <= div_in[i];
         end
      end
   end

   assign out_valid    = vld_ff[STEPS];
   assign out_radius   = div_ff[STEPS-1].zero ? '0 : div_ff[STEPS-1].quo;
   assign out_prod     = div_ff[STEPS-1].prod;
   assign out_in_range = div_ff[STEPS-1].in_range;

endmodule

// ===== src/ocf_cbrt.sv =====
`timescale 1ns / 1ps
// Pipelined digit-by-digit cube root that forms R^(2/3) from the radius,
// one root bit per stage with running square and cube. Depends on ocf_pkg.
module ocf_cbrt #(
   parameter int FRAC_BITS = ocf_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [ocf_pkg::ROOT_W-1:0]          in_radius,
   input  logic [ocf_pkg::FACTOR_W+ocf_pkg::DEPTH_W+ocf_pkg::WIDTH_W-2*FRAC_BITS-1:0] in_prod,
   input  logic                                in_in_range,
   output logic                                out_valid,
   output logic [ocf_pkg::ROOT_W-1:0]          out_root,
   output logic [ocf_pkg::FACTOR_W+ocf_pkg::DEPTH_W+ocf_pkg::WIDTH_W-2*FRAC_BITS-1:0] out_prod,
   output logic                                out_in_range
);
   import ocf_pkg::*;

   localparam int B_W    = FACTOR_W + DEPTH_W + WIDTH_W - 2 * FRAC_BITS;
   localparam int SQ_W   = 2 * ROOT_W;
   localparam int LIM_W  = SQ_W + FRAC_BITS;
   localparam int CUBE_W = 3 * ROOT_W + 1;
   localparam int STEPS  = ROOT_W;

   typedef struct packed {
      logic             in_range;
      logic [B_W-1:0]   prod;
      logic [LIM_W-1:0] lim;
   } front_type;

   typedef struct packed {
      logic              in_range;
      logic [B_W-1:0]    prod;
      logic [LIM_W-1:0]  lim;
      logic [ROOT_W-1:0] y;
      logic [SQ_W-1:0]   y2;
      logic [CUBE_W-1:0] y3;
   } root_type;

   logic [STEPS:0]  vld_ff;
   front_type       front_ff, front_in;
   root_type        root_ff [STEPS];
   root_type        root_in [STEPS];
   logic [SQ_W-1:0] sq;

   always_comb begin
      sq                = SQ_W'(in_radius) * SQ_W'(in_radius);
      front_in.in_range = in_in_range;
      front_in.prod     = in_prod;
      front_in.lim      = {sq, {FRAC_BITS{1'b1}}};
   end

   always_comb begin
      root_type          src;
      logic [CUBE_W-1:0] cand3;
      for (int i = 0; i < STEPS; i++) begin
         if (i == 0) begin
            src.in_range = front_ff.in_range;
            src.prod     = front_ff.prod;
            src.lim      = front_ff.lim;
            src.y        = '0;
            src.y2       = '0;
            src.y3       = '0;
         end else begin
            src = root_ff[i-1];
         end
         root_in[i] = src;
         cand3 = src.y3
               + ((CUBE_W'(src.y2) + (CUBE_W'(src.y2) << 1)) << (STEPS - 1 - i))
               + ((CUBE_W'(src.y) + (CUBE_W'(src.y) << 1)) << (2 * (STEPS - 1 - i)))
               + (CUBE_W'(1) << (3 * (STEPS - 1 - i)));
         if (cand3 <= CUBE_W'(src.lim)) begin
            root_in[i].y3              = cand3;
            root_in[i].y2              = src.y2 + (SQ_W'(src.y) << (STEPS - i))
                                       + (SQ_W'(1) << (2 * (STEPS - 1 - i)));
            root_in[i].y[STEPS - 1 - i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STEPS-1:0], in_valid};
      end
      if (advance) begin
         front_ff <= front_in;
         for (int i = 0; i < STEPS; i++) begin
            root_ff[i] <= root_in[i];
         end
      end
   end

   assign out_valid    = vld_ff[STEPS];
   assign out_root     = root_ff[STEPS-1].y;
   assign out_prod     = root_ff[STEPS-1].prod;
   assign out_in_range = root_ff[STEPS-1].in_range;

endmodule

// ===== src/ocf_flow.sv =====
`timescale 1ns / 1ps
// Final discharge product over two stages: split partial products, then
// the sum, scaling and saturation of the flow. Depends on ocf_pkg.
module ocf_flow #(
   parameter int FRAC_BITS = ocf_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [ocf_pkg::ROOT_W-1:0]          in_root,
   input  logic [ocf_pkg::FACTOR_W+ocf_pkg::DEPTH_W+ocf_pkg::WIDTH_W-2*FRAC_BITS-1:0] in_prod,
   input  logic                                in_in_range,
   output logic                                out_valid,
   output logic [ocf_pkg::FLOW_W-1:0]          out_flow,
   output logic                                out_in_range
);
   import ocf_pkg::*;

   localparam int B_W    = FACTOR_W + DEPTH_W + WIDTH_W - 2 * FRAC_BITS;
   localparam int LO_W   = (B_W + 1) / 2;
   localparam int HI_W   = B_W - LO_W;
   localparam int FULL_W = B_W + ROOT_W;

   logic [1:0]               vld_ff;
   logic                     rng0_ff, rng1_ff;
   logic [LO_W+ROOT_W-1:0]   plo_ff, plo_in;
   logic [HI_W+ROOT_W-1:0]   phi_ff, phi_in;
   logic [FLOW_W-1:0]        flow_ff, flow_in;
   logic [FULL_W-1:0]        full;
   logic [FULL_W-1:0]        scaled;

   always_comb begin
      plo_in  = (LO_W+ROOT_W)'(in_prod[LO_W-1:0]) * (LO_W+ROOT_W)'(in_root);
      phi_in  = (HI_W+ROOT_W)'(in_prod[B_W-1:LO_W]) * (HI_W+ROOT_W)'(in_root);
      full    = (FULL_W'(phi_ff) << LO_W) + FULL_W'(plo_ff);
      scaled  = full >> FRAC_BITS;
      flow_in = (|scaled[FULL_W-1:FLOW_W]) ? '1 : scaled[FLOW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
      if (advance) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         rng0_ff <= in_in_range;
         flow_ff <= flow_in;
         rng1_ff <= rng0_ff;
      end
   end

   assign out_valid    = vld_ff[1];
   assign out_flow     = flow_ff;
   assign out_in_range = rng1_ff;

endmodule

// ===== src/ocf_error.sv =====
`timescale 1ns / 1ps
// Percent error against the target through a pipelined restoring divider,
// with saturation, tolerance check and range masking. Depends on ocf_pkg.
module ocf_error #(
   parameter int FRAC_BITS = ocf_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [ocf_pkg::FLOW_W-1:0]          in_flow,
   input  logic                                in_in_range,
   input  logic [ocf_pkg::TARGET_W-1:0]        cfg_target,
   input  logic [ocf_pkg::TOL_W-1:0]           cfg_tolerance,
   output logic                                out_valid,
   output logic [ocf_pkg::FLOW_W-1:0]          out_flow,
   output logic [ocf_pkg::ERR_W-1:0]           out_error,
   output logic                                out_in_range,
   output logic                                out_tol_ok
);
   import ocf_pkg::*;

   localparam int PCT_W   = FLOW_W + 7;
   localparam int DVD_W   = PCT_W + FRAC_BITS;
   localparam int STEPS   = ERR_W;
   localparam int SH_W    = TARGET_W + ERR_W - 1;
   localparam int CW      = ((DVD_W > SH_W) ? DVD_W : SH_W) + 1;
   localparam int PERCENT = 100;
   localparam logic [ERR_W-1:0] MAG_LIM = ERR_W'(1) << (ERR_W - 1);

   typedef struct packed {
      logic                in_range;
      logic                neg;
      logic [FLOW_W-1:0]   flow;
      logic [TARGET_W-1:0] t;
      logic [DVD_W-1:0]    dvd;
   } front_type;

   typedef struct packed {
      logic                in_range;
      logic                neg;
      logic                ovf;
      logic [FLOW_W-1:0]   flow;
      logic [TARGET_W-1:0] t;
      logic [DVD_W-1:0]    rem;
      logic [ERR_W-1:0]    quo;
   } div_type;

   typedef struct packed {
      logic [FLOW_W-1:0] flow;
      logic [ERR_W-1:0]  err;
      logic              in_range;
      logic              tol_ok;
   } fin_type;

   logic [STEPS+1:0]    vld_ff;
   front_type           front_ff, front_in;
   div_type             div_ff [STEPS];
   div_type             div_in [STEPS];
   fin_type             fin_ff, fin_in;
   logic [TARGET_W-1:0] tgt;
   logic [FLOW_W-1:0]   diff;
   logic [PCT_W-1:0]    diff100;

   always_comb begin
      tgt               = (cfg_target == '0) ? TARGET_W'(1) : cfg_target;
      front_in.in_range = in_in_range;
      front_in.neg      = in_flow > tgt;
      front_in.flow     = in_flow;
      front_in.t        = tgt;
      diff              = front_in.neg ? (in_flow - tgt) : (tgt - in_flow);
      diff100           = PCT_W'(diff) * PCT_W'(PERCENT);
      front_in.dvd      = DVD_W'(diff100) << FRAC_BITS;
   end

   always_comb begin
      div_type       src;
      logic [CW-1:0] shifted;
      for (int i = 0; i < STEPS; i++) begin
         if (i == 0) begin
            src.in_range = front_ff.in_range;
            src.neg      = front_ff.neg;
            src.ovf      = CW'(front_ff.dvd) >= (CW'(front_ff.t) << ERR_W);
            src.flow     = front_ff.flow;
            src.t        = front_ff.t;
            src.rem      = front_ff.dvd;
            src.quo      = '0;
         end else begin
            src = div_ff[i-1];
         end
         div_in[i] = src;
         shifted   = CW'(src.t) << (STEPS - 1 - i);
         if (CW'(src.rem) >= shifted) begin
            div_in[i].rem                = src.rem - DVD_W'(shifted);
            div_in[i].quo[STEPS - 1 - i] = 1'b1;
         end
      end
   end

   always_comb begin
      logic             sat;
      logic [ERR_W-1:0] mag;
      sat             = div_ff[STEPS-1].ovf || (div_ff[STEPS-1].quo > MAG_LIM);
      mag             = (div_ff[STEPS-1].neg && sat) ? MAG_LIM : div_ff[STEPS-1].quo;
      fin_in.in_range = div_ff[STEPS-1].in_range;
      if (div_ff[STEPS-1].in_range) begin
         fin_in.flow   = div_ff[STEPS-1].flow;
         fin_in.err    = div_ff[STEPS-1].neg ? (ERR_W'(0) - mag) : mag;
         fin_in.tol_ok = mag <= ERR_W'(cfg_tolerance);
      end else begin
         fin_in.flow   = '0;
         fin_in.err    = '0;
         fin_in.tol_ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STEPS:0], in_valid};
      end
      if (advance) begin
         front_ff <= front_in;
         for (int i = 0; i < STEPS; i++) begin
            div_ff[i] <= div_in[i];
         end
         fin_ff <= fin_in;
      end
   end

   assign out_valid    = vld_ff[STEPS+1];
   assign out_flow     = fin_ff.flow;
   assign out_error    = fin_ff.err;
   assign out_in_range = fin_ff.in_range;
   assign out_tol_ok   = fin_ff.tol_ok;

endmodule

// ===== src/open_channel_flow_from_depth.sv =====
`timescale 1ns / 1ps
// Open-channel discharge from depth by Manning's equation, top level.
// Depends on ocf_pkg, ocf_radius, ocf_cbrt, ocf_flow and ocf_error.
//
// The block takes one depth item per clock while req_ready is high and
// returns one result item per depth, in order. The pipeline is made of the
// bit-per-stage radius divider (25 stages), the bit-per-stage cube root
// (25 stages), the two-stage flow product, the 34-stage percent-error divider
// and the output register. All pipeline stages
// move together; an output register with a skid entry lets the pipeline keep
// accepting while one result waits, so req_ready depends only on internal state.
// Configuration registers must be written only while no item is in flight.
module open_channel_flow_from_depth #(
   parameter int FRAC_BITS = ocf_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ocf_pkg::DEPTH_W-1:0]         req_depth,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ocf_pkg::FLOW_W-1:0]          rsp_flow,
   output logic signed [ocf_pkg::ERR_W-1:0]    rsp_error_percent,
   output logic                                rsp_depth_in_range,
   output logic                                rsp_within_tolerance,
   input  logic                                csr_write_en,
   input  logic [ocf_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [ocf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ocf_pkg::*;

   localparam int B_W = FACTOR_W + DEPTH_W + WIDTH_W - 2 * FRAC_BITS;

   localparam logic [WIDTH_W-1:0]  RST_WIDTH     = WIDTH_W'(983040);
   localparam logic [FACTOR_W-1:0] RST_FACTOR    = FACTOR_W'(269411);
   localparam logic [TARGET_W-1:0] RST_TARGET    = TARGET_W'(65536000);
   localparam logic [MAXD_W-1:0]   RST_MAX_DEPTH = MAXD_W'(655360);
   localparam logic [TOL_W-1:0]    RST_TOLERANCE = TOL_W'(6554);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CHANNEL_WIDTH = 3'd0,
      CSR_FLOW_FACTOR   = 3'd1,
      CSR_TARGET_FLOW   = 3'd2,
      CSR_MAX_DEPTH     = 3'd3,
      CSR_TOLERANCE     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [FLOW_W-1:0] flow;
      logic [ERR_W-1:0]  err;
      logic              in_range;
      logic              tol_ok;
   } rsp_type;

   logic [WIDTH_W-1:0]  width_ff;
   logic [FACTOR_W-1:0] factor_ff;
   logic [TARGET_W-1:0] target_ff;
   logic [MAXD_W-1:0]   max_depth_ff;
   logic [TOL_W-1:0]    tol_ff;

   logic                advance;
   logic                rad_valid, rad_in_range;
   logic [ROOT_W-1:0]   rad_radius;
   logic [B_W-1:0]      rad_prod;
   logic                cbrt_valid, cbrt_in_range;
   logic [ROOT_W-1:0]   cbrt_root;
   logic [B_W-1:0]      cbrt_prod;
   logic                flow_valid, flow_in_range;
   logic [FLOW_W-1:0]   flow_value;
   logic                pipe_valid;
   rsp_type             pipe_rsp;
   logic                out_valid_ff, skid_valid_ff;
   rsp_type             out_ff, skid_ff;
   logic                push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RST_WIDTH;
         factor_ff    <= RST_FACTOR;
         target_ff    <= RST_TARGET;
         max_depth_ff <= RST_MAX_DEPTH;
         tol_ff       <= RST_TOLERANCE;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHANNEL_WIDTH: width_ff     <= csr_wdata[WIDTH_W-1:0];
            CSR_FLOW_FACTOR:   factor_ff    <= csr_wdata[FACTOR_W-1:0];
            CSR_TARGET_FLOW:   target_ff    <= csr_wdata[TARGET_W-1:0];
            CSR_MAX_DEPTH:     max_depth_ff <= csr_wdata[MAXD_W-1:0];
            CSR_TOLERANCE:     tol_ff       <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   ocf_radius #(.FRAC_BITS(FRAC_BITS)) u_radius (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req_valid),
      .in_depth      (req_depth),
      .cfg_width     (width_ff),
      .cfg_factor    (factor_ff),
      .cfg_max_depth (max_depth_ff),
      .out_valid     (rad_valid),
      .out_radius    (rad_radius),
      .out_prod      (rad_prod),
      .out_in_range  (rad_in_range)
   );

   ocf_cbrt #(.FRAC_BITS(FRAC_BITS)) u_cbrt (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (rad_valid),
      .in_radius    (rad_radius),
      .in_prod      (rad_prod),
      .in_in_range  (rad_in_range),
      .out_valid    (cbrt_valid),
      .out_root     (cbrt_root),
      .out_prod     (cbrt_prod),
      .out_in_range (cbrt_in_range)
   );

   ocf_flow #(.FRAC_BITS(FRAC_BITS)) u_flow (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (cbrt_valid),
      .in_root      (cbrt_root),
      .in_prod      (cbrt_prod),
      .in_in_range  (cbrt_in_range),
      .out_valid    (flow_valid),
      .out_flow     (flow_value),
      .out_in_range (flow_in_range)
   );

   ocf_error #(.FRAC_BITS(FRAC_BITS)) u_error (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (flow_valid),
      .in_flow       (flow_value),
      .in_in_range   (flow_in_range),
      .cfg_target    (target_ff),
      .cfg_tolerance (tol_ff),
      .out_valid     (pipe_valid),
      .out_flow      (pipe_rsp.flow),
      .out_error     (pipe_rsp.err),
      .out_in_range  (pipe_rsp.in_range),
      .out_tol_ok    (pipe_rsp.tol_ok)
   );

   assign push = pipe_valid && advance;
   assign pop  = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff       <= pipe_rsp;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= pipe_rsp;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_flow             = out_ff.flow;
   assign rsp_error_percent    = $signed(out_ff.err);
   assign rsp_depth_in_range   = out_ff.in_range;
   assign rsp_within_tolerance = out_ff.tol_ok;

endmodule
